### rtl/pnps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Petri net pipeline step - shared definitions
// Sizes, codes and the token and control structures shared by the block.
// ----------------------------------------------------------------------------
package pnps_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int QUEUE_DEPTH = 16;
   localparam int REG_COUNT   = 8;
   localparam int MEM_WORDS   = 8;
   localparam int TAG_WIDTH   = 16;
   localparam int RES_DEPTH   = 4;
   localparam int FIELD_WIDTH = 32;

   localparam int REG_IDX_W  = $clog2(REG_COUNT);
   localparam int MEM_IDX_W  = $clog2(MEM_WORDS);
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int RES_IDX_W  = $clog2(RES_DEPTH);
   localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);
   localparam int CSR_ADDR_W = $clog2(MEM_WORDS * 4);

   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;
   localparam int RSP_PAD_W   = RSP_TDATA_W - FIELD_WIDTH - REG_IDX_W;

   typedef enum logic [1:0] {
      MODE_QUEUE  = 2'd0,
      MODE_PRESET = 2'd1,
      MODE_STEP   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_AND = 3'd2,
      OP_OR  = 3'd3,
      OP_LD  = 3'd4
   } opcode_type;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [REG_IDX_W-1:0]  ridx_type;
   typedef logic [TAG_WIDTH-1:0]  tag_type;

   typedef struct packed {
      opcode_type op;
      ridx_type   dest;
      ridx_type   src_a;
      ridx_type   src_b;
      tag_type    tag;
   } instr_type;

   typedef struct packed {
      opcode_type op;
      ridx_type   dest;
      data_type   v1;
      data_type   v2;
      tag_type    tag;
   } token_type;

   typedef struct packed {
      ridx_type dest;
      data_type value;
   } wb_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      opcode_type op;
      ridx_type   dest;
      ridx_type   src_a;
      ridx_type   src_b;
   } qctrl_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic [QCNT_W-1:0] count_next;
      tag_type           age;
      instr_type         front;
   } qstat_type;

   typedef struct packed {
      logic     step;
      logic     decode;
      logic     preset;
      ridx_type preset_reg;
      data_type preset_value;
   } nctrl_type;

   typedef struct packed {
      logic     reg_written;
      ridx_type written_reg;
      data_type written_value;
      logic     places_busy;
   } nstat_type;

endpackage

### rtl/petri_net_pipeline_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Petri net pipeline step - top level
// Request register, step control, result register and data memory registers.
// ----------------------------------------------------------------------------
// Each request word (queue an instruction, preset a register, or advance the
// net by one step) yields exactly one response word. A new request word can
// be taken every clock cycle while the response side keeps up; its response
// is offered once the step logic has worked on the request register and its
// outcome has landed in the response register.
// The rate is set by the combinational step logic: register-file read with
// write-back bypass into the decode place, beside the ALU and the load
// address adder. Out of reset the valid flags, pointers, counts, queue age,
// register file and data memory are cleared; no warm-up is needed.
module petri_net_pipeline_step_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // opcode, dest_reg, src_reg_a, src_reg_b, preset_value, zero pad
   input  logic [pnps_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // mode
   input  logic [pnps_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // written_reg, written_value, zero pad
   output logic [pnps_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // accepted, reg_written, busy_res
   output logic [pnps_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pnps_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pnps_pkg::FIELD_WIDTH-1:0]     csr_pwdata,
   output logic [pnps_pkg::FIELD_WIDTH-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam int QCW = pnps_pkg::QCNT_W;
   localparam int FW  = pnps_pkg::FIELD_WIDTH;
   localparam int DW  = pnps_pkg::DATA_WIDTH;
   localparam logic [QCW-1:0] QUEUE_FULL = QCW'(pnps_pkg::QUEUE_DEPTH);

   function automatic logic [FW-1:0] sext(pnps_pkg::data_type v);
      return FW'(signed'(v));
   endfunction

   logic                            req_valid_ff;
   logic [1:0]                      req_mode_ff;
   logic [2:0]                      req_opcode_ff;
   pnps_pkg::ridx_type              req_dest_ff, req_src_a_ff, req_src_b_ff;
   logic [FW-1:0]                   req_preset_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_accepted_ff, rsp_written_ff, rsp_busy_ff;
   pnps_pkg::ridx_type              rsp_reg_ff;
   logic [FW-1:0]                   rsp_value_ff;

   pnps_pkg::data_type              mem_ff [pnps_pkg::MEM_WORDS];
   pnps_pkg::data_type              mem_in [pnps_pkg::MEM_WORDS];
   logic                            csr_write;
   logic [pnps_pkg::MEM_IDX_W-1:0]  csr_idx;

   logic                            advance;
   pnps_pkg::mode_type              mode;
   logic                            is_queue, is_preset, is_step;
   logic                            accepted, busy;
   pnps_pkg::qctrl_type             qctrl;
   pnps_pkg::qstat_type             qstat;
   pnps_pkg::nctrl_type             nctrl;
   pnps_pkg::nstat_type             nstat;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign mode       = pnps_pkg::mode_type'(req_mode_ff);

   always_comb begin
      is_queue  = 1'b0;
      is_preset = 1'b0;
      is_step   = 1'b0;
      if (advance) begin
         unique case (mode)
            pnps_pkg::MODE_QUEUE:  is_queue  = 1'b1;
            pnps_pkg::MODE_PRESET: is_preset = 1'b1;
            pnps_pkg::MODE_STEP:   is_step   = 1'b1;
            default:               is_step   = 1'b0;
         endcase
      end
   end

   always_comb begin
      qctrl.push  = is_queue && (qstat.count < QUEUE_FULL) &&
                    (req_opcode_ff <= 3'(pnps_pkg::OP_LD));
      qctrl.pop   = is_step && (qstat.count != '0);
      qctrl.op    = pnps_pkg::opcode_type'(req_opcode_ff);
      qctrl.dest  = req_dest_ff;
      qctrl.src_a = req_src_a_ff;
      qctrl.src_b = req_src_b_ff;

      nctrl.step         = is_step;
      nctrl.decode       = qctrl.pop;
      nctrl.preset       = is_preset;
      nctrl.preset_reg   = req_dest_ff;
      nctrl.preset_value = req_preset_ff[DW-1:0];

      accepted = qctrl.push || is_preset || is_step;
      busy     = (qstat.count_next != '0) || nstat.places_busy;
   end

   pnps_iqueue u_iqueue (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (qctrl),
      .status (qstat)
   );

   pnps_net u_net (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (nctrl),
      .qfront   (qstat.front),
      .qage     (qstat.age),
      .mem_word (mem_ff),
      .status   (nstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_mode_ff   <= req_tuser[1:0];
         req_opcode_ff <= req_tdata[2:0];
         req_dest_ff   <= req_tdata[5:3];
         req_src_a_ff  <= req_tdata[8:6];
         req_src_b_ff  <= req_tdata[11:9];
         req_preset_ff <= req_tdata[43:12];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_accepted_ff <= accepted;
         rsp_written_ff  <= nstat.reg_written;
         rsp_reg_ff      <= nstat.written_reg;
         rsp_value_ff    <= sext(nstat.written_value);
         rsp_busy_ff     <= busy;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{pnps_pkg::RSP_PAD_W{1'b0}}, rsp_value_ff, rsp_reg_ff};
   assign rsp_tuser  = {rsp_busy_ff, rsp_written_ff, rsp_accepted_ff};

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[pnps_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = sext(mem_ff[csr_idx]);

   always_comb begin
      for (int i = 0; i < pnps_pkg::MEM_WORDS; i++) begin
         mem_in[i] = mem_ff[i];
         if (csr_write && csr_idx == pnps_pkg::MEM_IDX_W'(i)) begin
            mem_in[i] = csr_pwdata[DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pnps_pkg::MEM_WORDS; i++) begin
            mem_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < pnps_pkg::MEM_WORDS; i++) begin
            mem_ff[i] <= mem_in[i];
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= QUEUE_FULL)
      else $error("instruction queue count above depth");

   a_queue_reject: assert property (@(posedge clock) disable iff (reset)
      is_queue && (qstat.count == QUEUE_FULL) |=> rsp_valid_ff && !rsp_accepted_ff)
      else $error("full queue took an instruction");

   a_preset_silent: assert property (@(posedge clock) disable iff (reset)
      is_preset |=> rsp_valid_ff && rsp_accepted_ff && !rsp_written_ff)
      else $error("preset reported as a register write");

   a_write_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_written_ff |-> rsp_accepted_ff)
      else $error("register write on a rejected word");
`endif

endmodule

### rtl/pnps_iqueue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Petri net pipeline step - instruction queue
// Circular buffer of queued instructions, each tagged with its arrival age.
// ----------------------------------------------------------------------------
module pnps_iqueue (
   input  logic                clock,
   input  logic                reset,
   input  pnps_pkg::qctrl_type ctrl,
   output pnps_pkg::qstat_type status
);

   localparam int PW = pnps_pkg::QPTR_W;
   localparam logic [PW-1:0] LAST_PTR = PW'(pnps_pkg::QUEUE_DEPTH - 1);

   pnps_pkg::instr_type           entry_ff [pnps_pkg::QUEUE_DEPTH];
   logic [PW-1:0]                 head_ff, head_in;
   logic [PW-1:0]                 tail_ff, tail_in;
   logic [pnps_pkg::QCNT_W-1:0]   count_ff, count_in;
   pnps_pkg::tag_type             age_ff, age_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      age_in   = age_ff;
      if (ctrl.push) begin
         tail_in  = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
         age_in   = age_ff + 1'b1;
      end
      if (ctrl.pop) begin
         head_in  = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         age_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         age_ff   <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         entry_ff[tail_ff] <= '{op: ctrl.op, dest: ctrl.dest, src_a: ctrl.src_a,
                                src_b: ctrl.src_b, tag: age_ff};
      end
   end

   assign status.count      = count_ff;
   assign status.count_next = count_in;
   assign status.age        = age_ff;
   assign status.front      = entry_ff[head_ff];

endmodule

### rtl/pnps_net.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Petri net pipeline step - token places
// Decode, ALU, load, address and result places plus the register file;
// advances every occupied place by one token per step.
// ----------------------------------------------------------------------------
module pnps_net (
   input  logic                clock,
   input  logic                reset,
   input  pnps_pkg::nctrl_type ctrl,
   input  pnps_pkg::instr_type qfront,
   input  pnps_pkg::tag_type   qage,
   input  pnps_pkg::data_type  mem_word [pnps_pkg::MEM_WORDS],
   output pnps_pkg::nstat_type status
);

   localparam int DW  = pnps_pkg::DATA_WIDTH;
   localparam int RIW = pnps_pkg::RES_IDX_W;
   localparam int RCW = pnps_pkg::RES_CNT_W;
   localparam int GIW = pnps_pkg::REG_IDX_W;

   function automatic pnps_pkg::data_type alu_calc(pnps_pkg::opcode_type op,
                                                   pnps_pkg::data_type a,
                                                   pnps_pkg::data_type b);
      pnps_pkg::data_type r;
      unique case (op)
         pnps_pkg::OP_SUB: r = a - b;
         pnps_pkg::OP_AND: r = a & b;
         pnps_pkg::OP_OR:  r = a | b;
         default:          r = a + b;
      endcase
      return r;
   endfunction

   logic                 dec_valid_ff, dec_valid_in;
   logic                 alu_valid_ff, alu_valid_in;
   logic                 ld_valid_ff,  ld_valid_in;
   logic                 adr_valid_ff, adr_valid_in;
   pnps_pkg::token_type  dec_tok_ff, dec_tok_in;
   pnps_pkg::token_type  alu_tok_ff, alu_tok_in;
   pnps_pkg::token_type  ld_tok_ff,  ld_tok_in;
   pnps_pkg::token_type  adr_tok_ff, adr_tok_in;

   pnps_pkg::wb_type     res_ff [pnps_pkg::RES_DEPTH];
   pnps_pkg::wb_type     res_in [pnps_pkg::RES_DEPTH];
   logic [RIW-1:0]       res_head_ff, res_head_in;
   logic [RCW-1:0]       res_count_ff, res_count_in;

   pnps_pkg::data_type   regfile_ff [pnps_pkg::REG_COUNT];
   pnps_pkg::data_type   regfile_in [pnps_pkg::REG_COUNT];

   logic                 wb_valid;
   pnps_pkg::wb_type     wb;
   pnps_pkg::data_type   src_a_val, src_b_val;
   pnps_pkg::wb_type     alu_wb, ld_wb, first_wb, second_wb;
   pnps_pkg::data_type   adr_sum, mem_value;
   pnps_pkg::tag_type    age_alu, age_adr;
   logic                 push_first, push_second;
   logic [RIW-1:0]       res_tail0, res_tail1;

   always_comb begin
      wb_valid  = ctrl.step && (res_count_ff != '0);
      wb        = res_ff[res_head_ff];
      src_a_val = (wb_valid && wb.dest == qfront.src_a) ? wb.value : regfile_ff[qfront.src_a];
      src_b_val = (wb_valid && wb.dest == qfront.src_b) ? wb.value : regfile_ff[qfront.src_b];

      alu_wb    = '{dest: alu_tok_ff.dest,
                    value: alu_calc(alu_tok_ff.op, alu_tok_ff.v1, alu_tok_ff.v2)};
      adr_sum   = ld_tok_ff.v1 + ld_tok_ff.v2;
      mem_value = (adr_tok_ff.v1 < DW'(pnps_pkg::MEM_WORDS)) ?
                  mem_word[adr_tok_ff.v1[pnps_pkg::MEM_IDX_W-1:0]] : '0;
      ld_wb     = '{dest: adr_tok_ff.dest, value: mem_value};

      // older token lands in the result buffer first
      age_alu   = qage - alu_tok_ff.tag;
      age_adr   = qage - adr_tok_ff.tag;
      if (adr_valid_ff && alu_valid_ff) begin
         first_wb  = (age_adr > age_alu) ? ld_wb : alu_wb;
         second_wb = (age_adr > age_alu) ? alu_wb : ld_wb;
      end else begin
         first_wb  = adr_valid_ff ? ld_wb : alu_wb;
         second_wb = alu_wb;
      end
      push_first  = ctrl.step && (adr_valid_ff || alu_valid_ff);
      push_second = ctrl.step && adr_valid_ff && alu_valid_ff;
      res_tail0   = res_head_ff + res_count_ff[RIW-1:0];
      res_tail1   = res_tail0 + 1'b1;

      dec_valid_in = dec_valid_ff;
      alu_valid_in = alu_valid_ff;
      ld_valid_in  = ld_valid_ff;
      adr_valid_in = adr_valid_ff;
      dec_tok_in   = dec_tok_ff;
      alu_tok_in   = alu_tok_ff;
      ld_tok_in    = ld_tok_ff;
      adr_tok_in   = adr_tok_ff;
      if (ctrl.step) begin
         dec_valid_in  = ctrl.decode;
         dec_tok_in    = '{op: qfront.op, dest: qfront.dest, v1: src_a_val,
                           v2: src_b_val, tag: qfront.tag};
         alu_valid_in  = dec_valid_ff && (dec_tok_ff.op != pnps_pkg::OP_LD);
         alu_tok_in    = dec_tok_ff;
         ld_valid_in   = dec_valid_ff && (dec_tok_ff.op == pnps_pkg::OP_LD);
         ld_tok_in     = dec_tok_ff;
         adr_valid_in  = ld_valid_ff;
         adr_tok_in    = ld_tok_ff;
         adr_tok_in.v1 = adr_sum;
      end

      res_head_in  = wb_valid ? res_head_ff + 1'b1 : res_head_ff;
      res_count_in = res_count_ff + RCW'(push_first) + RCW'(push_second) - RCW'(wb_valid);
      for (int i = 0; i < pnps_pkg::RES_DEPTH; i++) begin
         res_in[i] = res_ff[i];
         if (push_second && res_tail1 == RIW'(i)) begin
            res_in[i] = second_wb;
         end
         if (push_first && res_tail0 == RIW'(i)) begin
            res_in[i] = first_wb;
         end
      end

      for (int i = 0; i < pnps_pkg::REG_COUNT; i++) begin
         regfile_in[i] = regfile_ff[i];
         if (wb_valid && wb.dest == GIW'(i)) begin
            regfile_in[i] = wb.value;
         end
         if (ctrl.preset && ctrl.preset_reg == GIW'(i)) begin
            regfile_in[i] = ctrl.preset_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
         alu_valid_ff <= 1'b0;
         ld_valid_ff  <= 1'b0;
         adr_valid_ff <= 1'b0;
         res_head_ff  <= '0;
         res_count_ff <= '0;
         for (int i = 0; i < pnps_pkg::REG_COUNT; i++) begin
            regfile_ff[i] <= '0;
         end
      end else begin
         dec_valid_ff <= dec_valid_in;
         alu_valid_ff <= alu_valid_in;
         ld_valid_ff  <= ld_valid_in;
         adr_valid_ff <= adr_valid_in;
         res_head_ff  <= res_head_in;
         res_count_ff <= res_count_in;
         for (int i = 0; i < pnps_pkg::REG_COUNT; i++) begin
            regfile_ff[i] <= regfile_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      dec_tok_ff <= dec_tok_in;
      alu_tok_ff <= alu_tok_in;
      ld_tok_ff  <= ld_tok_in;
      adr_tok_ff <= adr_tok_in;
      for (int i = 0; i < pnps_pkg::RES_DEPTH; i++) begin
         res_ff[i] <= res_in[i];
      end
   end

   assign status.reg_written   = wb_valid;
   assign status.written_reg   = wb_valid ? wb.dest : '0;
   assign status.written_value = wb_valid ? wb.value : '0;
   assign status.places_busy   = dec_valid_in || alu_valid_in || ld_valid_in ||
                                 adr_valid_in || (res_count_in != '0);

endmodule
